// ===== hdl/mmbd_pkg.sv =====
// Shared constants and types for the min/max bucket decimator.
// No dependencies; imported by every module of the block.
`default_nettype none
package mmbd_pkg;

  // fixed port widths of the sample and point fields
  localparam int FIELD_BITS     = 32;
  localparam int LEN_REG_BITS   = 24;
  localparam int BUDGET_BITS    = 16;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_BUDGET  = 2'd1;
  localparam logic [BUDGET_BITS-1:0]    BUDGET_RESET      = 16'd256;

  // four points per bucket: bucket count is budget shifted down by two
  localparam int BUDGET_SHIFT = 2;

  // default parameter values
  localparam int COUNT_BITS_DEF = 24;
  localparam int VALUE_BITS_DEF = 32;
  localparam int TIME_BITS_DEF  = 32;

  // bucket record queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic not_empty;
  } mmbd_q_stat_t;

endpackage
`default_nettype wire

// ===== hdl/mmbd_divider.sv =====
// Bucket width unit: ceil(window_length / max(budget/4, 1)), one quotient bit a cycle.
// Width is 1 instead when point_budget is 0 or window_length <= point_budget. Depends on mmbd_pkg.
`default_nettype none
module mmbd_divider #(
  parameter int COUNT_BITS = mmbd_pkg::COUNT_BITS_DEF,
  parameter int LEN_W      = mmbd_pkg::LEN_REG_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [LEN_W-1:0]                 window_length,
  input  logic [mmbd_pkg::BUDGET_BITS-1:0] point_budget,
  output logic                             busy,
  output logic [COUNT_BITS-1:0]            bucket_width
);
  import mmbd_pkg::*;

  localparam int CW   = BUDGET_BITS - BUDGET_SHIFT;
  localparam int NB   = ((LEN_W > CW) ? LEN_W : CW) + 1;
  localparam int CMPW = (LEN_W > BUDGET_BITS) ? LEN_W : BUDGET_BITS;
  localparam int QW   = (NB > COUNT_BITS) ? NB : COUNT_BITS;
  localparam int IW   = $clog2(NB + 1);

  typedef enum logic {DIV_IDLE, DIV_RUN} div_state_t;

  div_state_t            state_r;
  logic                  start_r;
  logic [IW-1:0]         iter_r;
  logic [CW-1:0]         rem_r;
  logic [CW-1:0]         div_r;
  logic [NB-1:0]         num_r;
  logic [COUNT_BITS-1:0] width_r;

  logic [CW-1:0]         budget_q;
  logic [CW-1:0]         divisor;
  logic                  bypass;
  logic [NB-1:0]         numer;
  logic [CW:0]           trial;
  logic                  ge;
  logic [CW:0]           trial_sub;
  logic [NB-1:0]         num_step;
  logic [QW-1:0]         quot_ext;
  logic [COUNT_BITS-1:0] quot;

  // operand setup and one restoring step
  always_comb begin
    budget_q  = point_budget[BUDGET_BITS-1:BUDGET_SHIFT];
    divisor   = (budget_q == '0) ? CW'(1) : budget_q;
    bypass    = (point_budget == '0) ||
                (CMPW'(window_length) <= CMPW'(point_budget));
    numer     = NB'(window_length) + NB'(divisor) - NB'(1);
    trial     = {rem_r, num_r[NB-1]};
    ge        = (trial >= {1'b0, div_r});
    trial_sub = trial - {1'b0, div_r};
    num_step  = {num_r[NB-2:0], ge};
    quot_ext  = QW'(num_step);
    quot      = quot_ext[COUNT_BITS-1:0];
  end

  // sequencer, state and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      start_r <= 1'b0;
      iter_r  <= '0;
      width_r <= COUNT_BITS'(1);
    end else begin
      start_r <= start;
      case (state_r)
        DIV_IDLE: begin
          if (start_r) begin
            if (bypass) begin
              width_r <= COUNT_BITS'(1);
            end else begin
              state_r <= DIV_RUN;
              iter_r  <= '0;
            end
          end
        end
        DIV_RUN: begin
          // a register write while running restarts from the new values
          if (start_r) begin
            iter_r <= '0;
            if (bypass) begin
              state_r <= DIV_IDLE;
              width_r <= COUNT_BITS'(1);
            end
          end else begin
            iter_r <= iter_r + IW'(1);
            if (iter_r == IW'(NB - 1)) begin
              state_r <= DIV_IDLE;
              width_r <= (quot == '0) ? COUNT_BITS'(1) : quot;
            end
          end
        end
        default: state_r <= DIV_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start_r) begin
      rem_r <= '0;
      div_r <= divisor;
      num_r <= numer;
    end else if (state_r == DIV_RUN) begin
      rem_r <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
      num_r <= num_step;
    end
  end

  assign busy         = start_r || (state_r == DIV_RUN);
  assign bucket_width = width_r;

endmodule
`default_nettype wire

// ===== hdl/mmbd_front.sv =====
// Front end: accepts samples, tracks first/min/max of the open bucket and
// pushes one bucket record when a bucket closes. Depends on mmbd_pkg.
`default_nettype none
module mmbd_front #(
  parameter int COUNT_BITS = mmbd_pkg::COUNT_BITS_DEF,
  parameter int VAL_W      = mmbd_pkg::VALUE_BITS_DEF,
  parameter int TIME_W     = mmbd_pkg::TIME_BITS_DEF,
  parameter int LEN_W      = mmbd_pkg::LEN_REG_BITS,
  parameter int REC_W      = 4 * (TIME_W + VAL_W) + 3 * COUNT_BITS + 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_fire,
  input  logic [mmbd_pkg::FIELD_BITS-1:0]        sample_time,
  input  logic signed [mmbd_pkg::FIELD_BITS-1:0] sample_value,
  input  logic [LEN_W-1:0]                       window_length,
  input  logic [COUNT_BITS-1:0]                  derived_width,
  output logic                                   push,
  output logic [REC_W-1:0]                       record
);
  import mmbd_pkg::*;

  localparam int CI = COUNT_BITS + 1;

  logic [COUNT_BITS-1:0]   sample_index_r, bucket_pos_r, bucket_width_r;
  logic [TIME_W-1:0]       first_t_r, low_t_r, high_t_r;
  logic signed [VAL_W-1:0] first_v_r, low_v_r, high_v_r;
  logic [COUNT_BITS-1:0]   low_pos_r, high_pos_r;

  logic [TIME_W-1:0]       first_t_nxt, low_t_nxt, high_t_nxt;
  logic signed [VAL_W-1:0] first_v_nxt, low_v_nxt, high_v_nxt;
  logic [COUNT_BITS-1:0]   low_pos_nxt, high_pos_nxt;
  logic [COUNT_BITS-1:0]   sample_index_nxt, bucket_pos_nxt;

  logic                    at_start, new_bucket, end_window, end_bucket;
  logic [COUNT_BITS-1:0]   pos, bw;
  logic [TIME_W-1:0]       t;
  logic signed [VAL_W-1:0] v;
  logic [CI-1:0]           idx_inc, pos_inc;

  // bucket tracking
  always_comb begin
    at_start   = (sample_index_r == '0);
    pos        = at_start ? '0 : bucket_pos_r;
    bw         = at_start ? derived_width : bucket_width_r;
    new_bucket = (pos == '0);
    t          = sample_time[TIME_W-1:0];
    v          = $signed(sample_value[VAL_W-1:0]);

    first_t_nxt  = new_bucket ? t : first_t_r;
    first_v_nxt  = new_bucket ? v : first_v_r;
    low_t_nxt    = low_t_r;
    low_v_nxt    = low_v_r;
    low_pos_nxt  = low_pos_r;
    high_t_nxt   = high_t_r;
    high_v_nxt   = high_v_r;
    high_pos_nxt = high_pos_r;
    if (new_bucket) begin
      low_t_nxt    = t;
      low_v_nxt    = v;
      low_pos_nxt  = '0;
      high_t_nxt   = t;
      high_v_nxt   = v;
      high_pos_nxt = '0;
    end else begin
      // strict compares keep the earliest extreme on ties
      if (v < low_v_r) begin
        low_t_nxt   = t;
        low_v_nxt   = v;
        low_pos_nxt = pos;
      end
      if (v > high_v_r) begin
        high_t_nxt   = t;
        high_v_nxt   = v;
        high_pos_nxt = pos;
      end
    end

    idx_inc    = {1'b0, sample_index_r} + CI'(1);
    pos_inc    = {1'b0, pos} + CI'(1);
    end_window = (idx_inc >= CI'(window_length));
    end_bucket = end_window || (pos_inc >= {1'b0, bw});

    if (end_window) begin
      sample_index_nxt = '0;
      bucket_pos_nxt   = '0;
    end else begin
      sample_index_nxt = idx_inc[COUNT_BITS-1:0];
      bucket_pos_nxt   = end_bucket ? '0 : pos_inc[COUNT_BITS-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      bucket_pos_r   <= '0;
      bucket_width_r <= COUNT_BITS'(1);
    end else if (in_fire) begin
      sample_index_r <= sample_index_nxt;
      bucket_pos_r   <= bucket_pos_nxt;
      if (at_start) begin
        bucket_width_r <= bw;
      end
    end
  end

  // bucket payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      first_t_r  <= first_t_nxt;
      first_v_r  <= first_v_nxt;
      low_t_r    <= low_t_nxt;
      low_v_r    <= low_v_nxt;
      low_pos_r  <= low_pos_nxt;
      high_t_r   <= high_t_nxt;
      high_v_r   <= high_v_nxt;
      high_pos_r <= high_pos_nxt;
    end
  end

  // record: end flag, positions, then last/high/low/first points
  assign push   = in_fire && end_bucket;
  assign record = {end_window, pos, high_pos_nxt, low_pos_nxt,
                   v, t, high_v_nxt, high_t_nxt,
                   low_v_nxt, low_t_nxt, first_v_nxt, first_t_nxt};

endmodule
`default_nettype wire

// ===== hdl/mmbd_queue.sv =====
// Small register queue of bucket records between front and back.
// Depends on mmbd_pkg for the status struct.
`default_nettype none
module mmbd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mmbd_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       rd_data,
  output mmbd_pkg::mmbd_q_stat_t stat
);
  import mmbd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data        = mem_r[rd_ptr_r];
  assign stat.full      = (count_r == NW'(DEPTH));
  assign stat.not_empty = (count_r != '0);

endmodule
`default_nettype wire

// ===== hdl/mmbd_back.sv =====
// Back end: orders the four candidate points of a bucket record by index, drops repeats
// and emits one word per cycle into the output register while out_stall does not hold it. Depends on mmbd_pkg.
`default_nettype none
module mmbd_back #(
  parameter int COUNT_BITS = mmbd_pkg::COUNT_BITS_DEF,
  parameter int VAL_W      = mmbd_pkg::VALUE_BITS_DEF,
  parameter int TIME_W     = mmbd_pkg::TIME_BITS_DEF,
  parameter int REC_W      = 4 * (TIME_W + VAL_W) + 3 * COUNT_BITS + 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [REC_W-1:0]                       record,
  input  logic                                   rec_avail,
  output logic                                   pop,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic [mmbd_pkg::FIELD_BITS-1:0]        point_time,
  output logic signed [mmbd_pkg::FIELD_BITS-1:0] point_value,
  output logic                                   point_last
);
  import mmbd_pkg::*;

  localparam int PTW = TIME_W + VAL_W;
  localparam int PB  = 4 * PTW;

  logic [3:0]             done_r;
  logic                   out_valid_r;
  logic [FIELD_BITS-1:0]  point_time_r;
  logic [FIELD_BITS-1:0]  point_value_r;
  logic                   point_last_r;

  logic [COUNT_BITS-1:0]  low_pos, high_pos, pos, m1_pos, m2_pos;
  logic                   end_window, lo_first, final_one, load;
  logic [3:0]             keep, pending, sel_hot;
  logic [1:0]             pt_idx;
  logic [TIME_W-1:0]      sel_t;
  logic [VAL_W-1:0]       sel_v;

  // slot order: first, earlier extreme, later extreme, last
  always_comb begin
    low_pos    = record[PB +: COUNT_BITS];
    high_pos   = record[PB + COUNT_BITS +: COUNT_BITS];
    pos        = record[PB + 2 * COUNT_BITS +: COUNT_BITS];
    end_window = record[REC_W-1];
    lo_first   = (low_pos <= high_pos);
    m1_pos     = lo_first ? low_pos : high_pos;
    m2_pos     = lo_first ? high_pos : low_pos;
    keep       = {(pos != m2_pos), (m2_pos != m1_pos), (m1_pos != '0), 1'b1};
    pending    = keep & ~done_r;

    // lowest pending slot goes next
    if (pending[0]) begin
      sel_hot = 4'b0001;
      pt_idx  = 2'd0;
    end else if (pending[1]) begin
      sel_hot = 4'b0010;
      pt_idx  = lo_first ? 2'd1 : 2'd2;
    end else if (pending[2]) begin
      sel_hot = 4'b0100;
      pt_idx  = lo_first ? 2'd2 : 2'd1;
    end else begin
      sel_hot = 4'b1000;
      pt_idx  = 2'd3;
    end
    final_one = ((pending & ~sel_hot) == 4'b0000);

    case (pt_idx)
      2'd0:    {sel_v, sel_t} = record[0 +: PTW];
      2'd1:    {sel_v, sel_t} = record[PTW +: PTW];
      2'd2:    {sel_v, sel_t} = record[2 * PTW +: PTW];
      default: {sel_v, sel_t} = record[3 * PTW +: PTW];
    endcase

    load = rec_avail && (!out_valid_r || !out_stall);
    pop  = load && final_one;
  end

  // emitted-slot mask and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r      <= final_one ? 4'b0000 : (done_r | sel_hot);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      point_time_r  <= FIELD_BITS'(sel_t);
      point_value_r <= FIELD_BITS'(sel_v);
      point_last_r  <= end_window && final_one;
    end
  end

  assign out_valid   = out_valid_r;
  assign point_time  = point_time_r;
  assign point_value = $signed(point_value_r);
  assign point_last  = point_last_r;

endmodule
`default_nettype wire

// ===== hdl/min_max_bucket_decimator.sv =====
// Min/max bucket decimator top level: config registers, width unit, front, queue, back.
// A point passes the record queue and the back end's output register before out_valid shows it.
// Throughput: one sample per cycle unless in_stall holds it; the back end emits one point per cycle
// unless out_stall holds it, up to four per bucket, and the two-record queue absorbs the bursts.
// A config write stalls the input while the bucket width divider runs one quotient bit per cycle;
// when the divider is bypassed, the stall lasts only while its registered start is pending.
// Reset: window_length 0, point_budget 256, bucket width 1, all control state cleared.
`default_nettype none
module min_max_bucket_decimator #(
  parameter int COUNT_BITS = mmbd_pkg::COUNT_BITS_DEF,
  parameter int VALUE_BITS = mmbd_pkg::VALUE_BITS_DEF,
  parameter int TIME_BITS  = mmbd_pkg::TIME_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [mmbd_pkg::FIELD_BITS-1:0]           in_sample_time,
  input  logic signed [mmbd_pkg::FIELD_BITS-1:0]    in_sample_value,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [mmbd_pkg::FIELD_BITS-1:0]           out_point_time,
  output logic signed [mmbd_pkg::FIELD_BITS-1:0]    out_point_value,
  output logic                                      out_point_last,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [mmbd_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [mmbd_pkg::CFG_DATA_BITS-1:0]        cfg_wdata
);
  import mmbd_pkg::*;

  localparam int VAL_W  = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int TIME_W = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;
  localparam int LEN_W  = (COUNT_BITS < LEN_REG_BITS) ? COUNT_BITS : LEN_REG_BITS;
  localparam int REC_W  = 4 * (TIME_W + VAL_W) + 3 * COUNT_BITS + 1;

  logic [LEN_W-1:0]       window_length_r;
  logic [BUDGET_BITS-1:0] point_budget_r;

  logic                   cfg_fire, in_fire;
  logic                   div_busy;
  logic [COUNT_BITS-1:0]  derived_width;
  logic                   push, pop;
  logic [REC_W-1:0]       push_rec, head_rec;
  mmbd_q_stat_t           q_stat;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = div_busy || cfg_valid || q_stat.full;
  assign in_fire   = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= '0;
      point_budget_r  <= BUDGET_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length_r <= cfg_wdata[LEN_W-1:0];
        REG_POINT_BUDGET:  point_budget_r  <= cfg_wdata[BUDGET_BITS-1:0];
        default:           ;
      endcase
    end
  end

  mmbd_divider #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_W      (LEN_W)
  ) u_divider (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (cfg_fire),
    .window_length (window_length_r),
    .point_budget  (point_budget_r),
    .busy          (div_busy),
    .bucket_width  (derived_width)
  );

  mmbd_front #(
    .COUNT_BITS (COUNT_BITS),
    .VAL_W      (VAL_W),
    .TIME_W     (TIME_W),
    .LEN_W      (LEN_W),
    .REC_W      (REC_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .sample_time   (in_sample_time),
    .sample_value  (in_sample_value),
    .window_length (window_length_r),
    .derived_width (derived_width),
    .push          (push),
    .record        (push_rec)
  );

  mmbd_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_rec),
    .pop     (pop),
    .rd_data (head_rec),
    .stat    (q_stat)
  );

  mmbd_back #(
    .COUNT_BITS (COUNT_BITS),
    .VAL_W      (VAL_W),
    .TIME_W     (TIME_W),
    .REC_W      (REC_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .record      (head_rec),
    .rec_avail   (q_stat.not_empty),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .point_time  (out_point_time),
    .point_value (out_point_value),
    .point_last  (out_point_last)
  );

  // no sample taken while the bucket width is being derived
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> !in_fire)
    else $error("sample accepted while bucket width divider busy");

  // a config write always starts a width update
  a_cfg_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> div_busy)
    else $error("config write did not start width update");

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("bucket record pushed into full queue");

  // settled bucket width is never zero
  a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy |-> (derived_width != '0))
    else $error("derived bucket width is zero");

endmodule
`default_nettype wire

// ===== tb/mmbd_checker.sv =====
// Scoreboard for the min/max bucket decimator: watches the sample, point and register channels.
// Keeps its own copy of the window and bucket state and checks every point in order.
// Depends on mmbd_pkg for register indexes, widths and the budget reset value.
module mmbd_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [mmbd_pkg::FIELD_BITS-1:0]        in_sample_time,
  input  logic signed [mmbd_pkg::FIELD_BITS-1:0] in_sample_value,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic [mmbd_pkg::FIELD_BITS-1:0]        out_point_time,
  input  logic signed [mmbd_pkg::FIELD_BITS-1:0] out_point_value,
  input  logic                                   out_point_last,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [mmbd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [mmbd_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  output int                                     fail_count,
  output int                                     pending
);
  import mmbd_pkg::*;

  typedef struct packed {
    logic [FIELD_BITS-1:0]        t;
    logic signed [FIELD_BITS-1:0] v;
    logic                         last;
  } point_t;

  point_t expected_points[$];
  int     mismatches = 0;
  int     outstanding = 0;

  // register copies
  logic [LEN_REG_BITS-1:0] window_len = '0;
  logic [BUDGET_BITS-1:0]  budget     = BUDGET_RESET;

  // window and bucket tracking
  logic [LEN_REG_BITS-1:0]      sample_idx = '0;
  logic [LEN_REG_BITS-1:0]      bucket_pos = '0;
  logic [LEN_REG_BITS-1:0]      bucket_w   = 24'd1;
  logic [FIELD_BITS-1:0]        first_t = '0, low_t = '0, high_t = '0;
  logic signed [FIELD_BITS-1:0] first_v = '0, low_v = '0, high_v = '0;
  logic [LEN_REG_BITS-1:0]      low_pos = '0, high_pos = '0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  // samples per bucket for a window length and point budget
  function automatic logic [LEN_REG_BITS-1:0] bucket_width_for(
    input logic [LEN_REG_BITS-1:0] n,
    input logic [BUDGET_BITS-1:0]  b
  );
    logic [31:0] buckets;
    logic [31:0] w;
    if (b == 0 || n <= b) return 24'd1;
    buckets = 32'(b >> BUDGET_SHIFT);
    if (buckets == 0) buckets = 32'd1;
    w = (32'(n) + buckets - 32'd1) / buckets;
    if (w[LEN_REG_BITS-1:0] == 0) return 24'd1;
    return w[LEN_REG_BITS-1:0];
  endfunction

  // advance the bucket state by one sample and queue the points it releases
  task automatic predict_points(
    input logic [FIELD_BITS-1:0]        t,
    input logic signed [FIELD_BITS-1:0] v
  );
    logic [LEN_REG_BITS-1:0] pos;
    logic                    end_win;
    logic                    end_bkt;
    logic [LEN_REG_BITS-1:0] p[4];
    point_t                  c[4];
    logic [LEN_REG_BITS-1:0] tmp_p;
    point_t                  tmp_c;
    point_t                  batch[$];
    logic                    have;
    logic [LEN_REG_BITS-1:0] prev;

    // width is latched at the start of each window
    if (sample_idx == 0) begin
      bucket_w   = bucket_width_for(window_len, budget);
      bucket_pos = '0;
    end
    pos = bucket_pos;

    if (pos == 0) begin
      first_t = t; first_v = v;
      low_t   = t; low_v   = v; low_pos  = '0;
      high_t  = t; high_v  = v; high_pos = '0;
    end else begin
      if (v < low_v) begin low_t = t; low_v = v; low_pos = pos; end
      if (v > high_v) begin high_t = t; high_v = v; high_pos = pos; end
    end

    end_win = ({1'b0, sample_idx} + 25'd1) >= {1'b0, window_len};
    end_bkt = end_win || (({1'b0, pos} + 25'd1) >= {1'b0, bucket_w});

    if (end_bkt) begin
      p[0] = '0;       c[0] = '{t: first_t, v: first_v, last: 1'b0};
      p[1] = low_pos;  c[1] = '{t: low_t,   v: low_v,   last: 1'b0};
      p[2] = high_pos; c[2] = '{t: high_t,  v: high_v,  last: 1'b0};
      p[3] = pos;      c[3] = '{t: t,       v: v,       last: 1'b0};
      // stable sort by position within the bucket
      for (int i = 1; i < 4; i++) begin
        for (int j = i; j > 0 && p[j-1] > p[j]; j--) begin
          tmp_p = p[j]; p[j] = p[j-1]; p[j-1] = tmp_p;
          tmp_c = c[j]; c[j] = c[j-1]; c[j-1] = tmp_c;
        end
      end
      // one point per distinct sample
      have = 1'b0;
      prev = '0;
      for (int i = 0; i < 4; i++) begin
        if (!(have && p[i] == prev)) begin
          batch = {batch, c[i]};
          prev = p[i];
          have = 1'b1;
        end
      end
      if (end_win) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) expected_points = {expected_points, batch[k]};
    end

    if (end_win) begin
      sample_idx = '0;
      bucket_pos = '0;
    end else begin
      sample_idx = sample_idx + 24'd1;
      bucket_pos = end_bkt ? '0 : pos + 24'd1;
    end
  endtask

  // channel monitor
  always @(posedge clk) begin
    point_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_LENGTH)
          window_len = cfg_wdata[LEN_REG_BITS-1:0];
        else if (cfg_index == REG_POINT_BUDGET)
          budget = cfg_wdata[BUDGET_BITS-1:0];
      end

      if (in_valid && !in_stall)
        predict_points(in_sample_time, in_sample_value);

      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected point: time %h value %0d last %b",
                     out_point_time, out_point_value, out_point_last);
        end else begin
          want = expected_points.pop_front();
          if (out_point_time !== want.t || out_point_value !== want.v ||
              out_point_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("point mismatch: time %h/%h value %0d/%0d last %b/%b (exp/act)",
                       want.t, out_point_time, want.v, out_point_value,
                       want.last, out_point_last);
          end
        end
      end
    end
    outstanding <= expected_points.size();
  end

endmodule

// ===== tb/min_max_bucket_decimator_tb.sv =====
// Testbench top for the min/max bucket decimator: clock, reset, stimulus and verdict.
// Drives samples, register writes and output back-pressure; mmbd_checker does the checking.
// Depends on mmbd_pkg, mmbd_checker and the min_max_bucket_decimator RTL.
module min_max_bucket_decimator_tb;
  import mmbd_pkg::*;

  localparam int LIMIT_TIME    = 7_200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int FILL_WORDS    = 60;
  localparam int RANDOM_ITEMS  = 380;
  // register indexes the block does not use
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [FIELD_BITS-1:0]        in_sample_time = '0;
  logic signed [FIELD_BITS-1:0] in_sample_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [FIELD_BITS-1:0]        out_point_time;
  logic signed [FIELD_BITS-1:0] out_point_value;
  logic                         out_point_last;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_wdata = '0;
  int                           fail_count;
  int                           pending;

  logic                         fill_request = 1'b0;
  logic                         fill_hold = 1'b0;
  logic                         gaps_on = 1'b0;
  logic [FIELD_BITS-1:0]        stamp = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  min_max_bucket_decimator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_time  (in_sample_time),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_time  (out_point_time),
    .out_point_value (out_point_value),
    .out_point_last  (out_point_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  mmbd_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_time  (in_sample_time),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_time  (out_point_time),
    .out_point_value (out_point_value),
    .out_point_last  (out_point_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // offer one sample word and hold it until accepted
  task automatic send_sample(
    input logic [FIELD_BITS-1:0]        t,
    input logic signed [FIELD_BITS-1:0] v
  );
    in_valid        <= 1'b1;
    in_sample_time  <= t;
    in_sample_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random sample with mixed value classes, then an optional idle gap
  task automatic send_random_sample();
    logic [FIELD_BITS-1:0]        t;
    logic signed [FIELD_BITS-1:0] v;
    int                           roll;
    int                           gap;
    if ($urandom_range(0, 7) == 0) begin
      t = $urandom;
    end else begin
      stamp = stamp + $urandom_range(1, 1000);
      t = stamp;
    end
    case ($urandom_range(0, 11))
      0:       v = 32'sh8000_0000;
      1:       v = 32'sh7fff_ffff;
      2, 3, 4: v = $signed(32'($urandom_range(0, 6))) - 32'sd3;
      default: v = $urandom;
    endcase
    send_sample(t, v);
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      gap = (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(15, 50);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait until every expected point has come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write word; valid stays high for a following write
  task automatic write_reg(
    input logic [CFG_INDEX_BITS-1:0] idx,
    input logic [CFG_DATA_BITS-1:0]  data
  );
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // program both registers while the block is idle
  task automatic configure(
    input logic [LEN_REG_BITS-1:0] wl,
    input logic [BUDGET_BITS-1:0]  bg
  );
    drain_outputs();
    write_reg(REG_WINDOW_LENGTH, wl);
    write_reg(REG_POINT_BUDGET, {8'($urandom), bg});
    cfg_valid <= 1'b0;
  endtask

  // output back-pressure: random holds, calm runs, one long hold on request
  initial begin : receiver
    logic fill_done;
    int   stall_for;
    int   run;
    int   roll;
    fill_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (fill_request && !fill_done) begin
        fill_done = 1'b1;
        stall_for = LONG_HOLD;
        fill_hold <= 1'b1;
      end else if (roll < 70) begin
        stall_for = 0;
      end else if (roll < 95) begin
        stall_for = $urandom_range(1, 4);
      end else begin
        stall_for = $urandom_range(10, 40);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
      if (stall_for != 0) begin
        out_stall <= 1'b1;
        repeat (stall_for) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat (run) @(posedge clk);
    end
  end

  initial begin : watchdog
    #(LIMIT_TIME);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int                      sent;
    int                      count;
    logic [LEN_REG_BITS-1:0] wl;
    logic [BUDGET_BITS-1:0]  bg;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: zero window length, every sample is a window of one
    send_sample(32'h0000_0000, 32'sh8000_0000);
    send_sample(32'hffff_ffff, 32'sh7fff_ffff);
    send_sample(32'h0000_0001, 32'sd0);
    send_sample(32'h0000_0002, -32'sd1);

    // one bucket of eight: repeated extremes, the earliest one wins
    configure(24'd8, 16'd4);
    send_sample(32'd100, 32'sd5);
    send_sample(32'd101, -32'sd3);
    send_sample(32'd102, 32'sd9);
    send_sample(32'd103, -32'sd3);
    send_sample(32'd104, 32'sd9);
    send_sample(32'd105, 32'sd2);
    send_sample(32'd106, 32'sd0);
    send_sample(32'd107, 32'sd1);

    // budget below four still gives one bucket; first is min and last is max
    configure(24'd3, 16'd2);
    send_sample(32'd200, 32'sd1);
    send_sample(32'd201, 32'sd2);
    send_sample(32'd202, 32'sd3);

    // spare indexes, then a window cut short by a live length write
    drain_outputs();
    write_reg(REG_SPARE_A, 24'($urandom));
    write_reg(REG_SPARE_B, 24'($urandom));
    write_reg(REG_WINDOW_LENGTH, 24'd10);
    write_reg(REG_POINT_BUDGET, 24'd8);
    cfg_valid <= 1'b0;
    send_sample(32'd300, 32'sd7);
    send_sample(32'd301, -32'sd7);
    send_sample(32'd302, 32'sd8);
    // budget change waits for the next window, length change is live
    drain_outputs();
    write_reg(REG_POINT_BUDGET, 24'd0);
    write_reg(REG_WINDOW_LENGTH, 24'd4);
    cfg_valid <= 1'b0;
    send_sample(32'd303, 32'sd1);
    send_sample(32'd304, 32'sd4);
    send_sample(32'd305, -32'sd4);

    // fill the block behind a long output hold
    configure(24'd0, 16'($urandom));
    gaps_on      <= 1'b0;
    fill_request <= 1'b1;
    @(posedge clk);
    while (!fill_hold) @(posedge clk);
    sent = 0;
    for (int k = 0; k < FILL_WORDS; k++) begin
      send_random_sample();
      sent++;
    end

    // random phases over a spread of lengths and budgets
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin wl = 24'd0; bg = 16'($urandom); count = 8; end
        1: begin wl = 24'd1; bg = 16'($urandom); count = 6; end
        2: begin wl = 24'hff_ffff; bg = 16'd0; count = 16; end
        3: begin wl = 24'd70000; bg = 16'hffff; count = 20; end
        4: begin
          wl    = 24'($urandom_range(2, 40));
          bg    = 16'($urandom_range(wl, 65535));
          count = 2 * wl;
        end
        default: begin
          wl    = 24'($urandom_range(2, 48));
          bg    = 16'($urandom_range(1, wl - 1));
          count = wl * $urandom_range(1, 3);
          if ($urandom_range(0, 3) == 0) count = count + $urandom_range(1, 3);
        end
      endcase
      configure(wl, bg);
      gaps_on <= ($urandom_range(0, 3) != 0);
      for (int k = 0; k < count && sent < RANDOM_ITEMS; k++) begin
        send_random_sample();
        sent++;
      end
    end

    drain_outputs();
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
